/* rtl/lps_pkg.sv */
package lps_pkg;

  localparam int MAX_COLUMNS   = 64;
  localparam int MAX_SCAN_ROWS = 32;
  localparam int MAX_PLANES    = 4;

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_SCAN_ROWS);
  localparam int PLANE_W = $clog2(MAX_PLANES);
  localparam int ADDR_W  = 1 + ROW_W + COL_W;
  localparam int RAM_DEPTH = 2 * MAX_SCAN_ROWS * MAX_COLUMNS;

  localparam int SEL_POS        = 6;
  localparam int OE_POS         = 11;
  localparam int LAT_POS        = 12;
  localparam int CLK_POS        = 13;
  localparam int UPPER_BLUE_POS = 14;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_SWAP    = 2'd2;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_PLANES  = 2'd2;

  localparam logic [6:0] COLUMNS_RESET = 7'd64;
  localparam logic [5:0] ROWS_RESET    = 6'd16;
  localparam logic [2:0] PLANES_RESET  = 3'd1;

  localparam logic [7:0] HOLD_TABLE [7] = '{8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64};

  typedef logic [ADDR_W-1:0] addr_t;
  // bit 0 red, bit 1 green, bit 2 blue
  typedef logic [2:0] rgb_t;

  // clamped register values
  typedef struct packed {
    logic [6:0] cols;
    logic [5:0] rows;
    logic [2:0] planes;
  } cfg_t;

  typedef struct packed {
    logic [MAX_PLANES-1:0]       we_upper;
    logic [MAX_PLANES-1:0]       we_lower;
    addr_t                       waddr;
    rgb_t [MAX_PLANES-1:0]       wdata;
    addr_t                       raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic               colour;
    logic               clk_bit;
    logic               oe;
    logic               lat;
    logic [4:0]         sel;
    logic [PLANE_W-1:0] plane;
    logic [3:0]         hold;
    logic               last;
  } word_info_t;

  function automatic logic [6:0] clamp_cols(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(MAX_COLUMNS)) return 7'(MAX_COLUMNS);
    return v;
  endfunction

  function automatic logic [5:0] clamp_rows(input logic [5:0] v);
    if (v == 6'd0) return 6'd1;
    if (v > 6'(MAX_SCAN_ROWS)) return 6'(MAX_SCAN_ROWS);
    return v;
  endfunction

  function automatic logic [2:0] clamp_planes(input logic [2:0] v);
    if (v == 3'd0) return 3'd1;
    if (v > 3'(MAX_PLANES)) return 3'(MAX_PLANES);
    return v;
  endfunction

endpackage

/* rtl/lps_apb_regs.sv */
module lps_apb_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output lps_pkg::cfg_t   cfg
);
  import lps_pkg::*;

  logic [6:0] panel_columns;
  logic [5:0] scan_rows;
  logic [2:0] planes_in_use;
  logic       wr_fire;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_columns <= COLUMNS_RESET;
      scan_rows     <= ROWS_RESET;
      planes_in_use <= PLANES_RESET;
    end else if (wr_fire) begin
      unique case (paddr[3:2])
        REG_COLUMNS: panel_columns <= pwdata[6:0];
        REG_ROWS:    scan_rows     <= pwdata[5:0];
        REG_PLANES:  planes_in_use <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COLUMNS: prdata = {25'd0, panel_columns};
      REG_ROWS:    prdata = {26'd0, scan_rows};
      REG_PLANES:  prdata = {29'd0, planes_in_use};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg.cols   = clamp_cols(panel_columns);
  assign cfg.rows   = clamp_rows(scan_rows);
  assign cfg.planes = clamp_planes(planes_in_use);

endmodule

/* rtl/lps_plane_ram.sv */
module lps_plane_ram (
  input  logic           clk,
  input  logic           we,
  input  lps_pkg::addr_t waddr,
  input  lps_pkg::rgb_t  wdata,
  input  lps_pkg::addr_t raddr,
  output lps_pkg::rgb_t  rdata
);
  import lps_pkg::*;

  rgb_t mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lps_scan_ctrl.sv */
module lps_scan_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          kind,
  input  logic [5:0]          col,
  input  logic [5:0]          row,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  lps_pkg::cfg_t       cfg,
  output logic                busy,
  output lps_pkg::mem_cmd_t   mem_cmd,
  output logic                s1_valid,
  output lps_pkg::word_info_t s1_info
);
  import lps_pkg::*;

  logic               show_first;
  logic [PLANE_W-1:0] scan_plane;
  logic [ROW_W-1:0]   scan_row;
  logic [7:0]         scan_slot;
  logic               clearing;
  addr_t              clear_addr;

  logic               show_first_next;
  logic [PLANE_W-1:0] scan_plane_next;
  logic [ROW_W-1:0]   scan_row_next;
  logic [7:0]         scan_slot_next;

  logic               accept;
  logic               do_write;
  logic               do_adv;
  logic [7:0]         cols2;
  logic [7:0]         slots;
  logic [PLANE_W-1:0] ep;
  logic [ROW_W-1:0]   er;
  logic [7:0]         es;
  logic [ROW_W-1:0]   rows_m1;
  logic [ROW_W-1:0]   prev;
  logic [7:0]         slot_inc;
  logic [ROW_W-1:0]   row_inc;
  logic [PLANE_W:0]   plane_inc;
  logic [PLANE_W:0]   swap_inc;
  logic               wr_ok;
  logic               upper;
  logic [ROW_W-1:0]   r_local;
  word_info_t         info;

  assign busy     = clearing;
  assign accept   = start && !busy;
  assign do_write = accept && (kind == KIND_WRITE);
  assign do_adv   = accept && (kind == KIND_ADVANCE);

  assign cols2   = {cfg.cols, 1'b0};
  assign slots   = cols2 + 8'd4;
  assign rows_m1 = ROW_W'(cfg.rows - 6'd1);

  // scan position with shrunk-configuration fixups applied
  always_comb begin
    ep = scan_plane;
    er = scan_row;
    es = scan_slot;
    if ({1'b0, ep} >= cfg.planes) begin
      ep = '0;
      er = '0;
      es = '0;
    end
    if ({1'b0, er} >= cfg.rows) begin
      er = '0;
      es = '0;
    end
    if (es >= slots) begin
      es = '0;
    end
  end

  assign prev = (er == '0) ? rows_m1 : er - ROW_W'(1);

  always_comb begin
    info       = '0;
    info.plane = ep;
    info.hold  = 4'(HOLD_TABLE[{1'b0, ep}]);
    info.last  = ({1'b0, ep} == cfg.planes - 3'd1) && ({1'b0, er} == cfg.rows - 6'd1)
                 && (es == slots - 8'd1);
    if (es < cols2) begin
      info.colour  = 1'b1;
      info.clk_bit = es[0];
      info.sel     = prev;
    end else if (es == cols2) begin
      info.oe  = 1'b1;
      info.sel = prev;
    end else if (es == cols2 + 8'd1) begin
      info.oe  = 1'b1;
      info.lat = 1'b1;
      info.sel = er;
    end else begin
      info.sel = er;
    end
  end

  assign slot_inc  = es + 8'd1;
  assign row_inc   = er + ROW_W'(1);
  assign plane_inc = {1'b0, ep} + 3'd1;
  assign swap_inc  = {1'b0, scan_plane} + 3'd1;

  always_comb begin
    show_first_next = show_first;
    scan_plane_next = scan_plane;
    scan_row_next   = scan_row;
    scan_slot_next  = scan_slot;
    if (accept) begin
      case (kind)
        KIND_ADVANCE: begin
          scan_plane_next = ep;
          scan_row_next   = er;
          scan_slot_next  = slot_inc;
          if (slot_inc >= slots) begin
            scan_slot_next = '0;
            scan_row_next  = row_inc;
            if ({1'b0, er} + 6'd1 >= cfg.rows) begin
              scan_row_next   = '0;
              scan_plane_next = (plane_inc >= cfg.planes) ? '0 : plane_inc[PLANE_W-1:0];
            end
          end
        end
        KIND_SWAP: begin
          show_first_next = !show_first;
          scan_plane_next = (swap_inc >= cfg.planes) ? '0 : swap_inc[PLANE_W-1:0];
          scan_row_next   = '0;
          scan_slot_next  = '0;
        end
        default: ;
      endcase
    end
  end

  // pixel write address and bank enables
  assign wr_ok   = ({1'b0, col} < cfg.cols) && ({1'b0, row} < {cfg.rows, 1'b0});
  assign upper   = row < cfg.rows;
  assign r_local = upper ? row[ROW_W-1:0] : ROW_W'(row - cfg.rows);

  always_comb begin
    mem_cmd.raddr = {!show_first, er, es[COL_W:1]};
    mem_cmd.waddr = clearing ? clear_addr : {show_first, r_local, col};
    for (int p = 0; p < MAX_PLANES; p++) begin
      mem_cmd.we_upper[p] = clearing || (do_write && wr_ok && upper && (3'(p) < cfg.planes));
      mem_cmd.we_lower[p] = clearing || (do_write && wr_ok && !upper && (3'(p) < cfg.planes));
      mem_cmd.wdata[p]    = clearing ? '0 : {blue[4+p], green[4+p], red[4+p]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      show_first <= 1'b1;
      scan_plane <= '0;
      scan_row   <= '0;
      scan_slot  <= '0;
      clearing   <= 1'b1;
      clear_addr <= '0;
      s1_valid   <= 1'b0;
    end else begin
      show_first <= show_first_next;
      scan_plane <= scan_plane_next;
      scan_row   <= scan_row_next;
      scan_slot  <= scan_slot_next;
      s1_valid   <= do_adv;
      if (clearing) begin
        clear_addr <= clear_addr + ADDR_W'(1);
        if (clear_addr == '1) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_info <= info;
  end

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clear_addr) == '1)
    else $error("clear pass ended early");

  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !s1_valid)
    else $error("advance issued during clear pass");

endmodule

/* rtl/lps_word_out.sv */
module lps_word_out (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s1_valid,
  input  lps_pkg::word_info_t                    s1_info,
  input  lps_pkg::rgb_t [lps_pkg::MAX_PLANES-1:0] rd_upper,
  input  lps_pkg::rgb_t [lps_pkg::MAX_PLANES-1:0] rd_lower,
  output logic                                   word_strobe,
  output logic [15:0]                            port_word,
  output logic [3:0]                             hold_ticks,
  output logic                                   frame_end
);
  import lps_pkg::*;

  rgb_t        up;
  rgb_t        lo;
  logic [15:0] word;

  always_comb begin
    up   = s1_info.colour ? rd_upper[s1_info.plane] : '0;
    lo   = s1_info.colour ? rd_lower[s1_info.plane] : '0;
    word = '0;
    word[0]              = up[0];
    word[1]              = up[1];
    word[UPPER_BLUE_POS] = up[2];
    word[5:3]            = lo;
    word[SEL_POS+4:SEL_POS] = s1_info.sel;
    word[OE_POS]         = s1_info.oe;
    word[LAT_POS]        = s1_info.lat;
    word[CLK_POS]        = s1_info.clk_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_strobe <= 1'b0;
    end else begin
      word_strobe <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    port_word  <= word;
    hold_ticks <= s1_info.hold;
    frame_end  <= s1_info.last;
  end

  a_latch_with_blank: assert property (@(posedge clk) disable iff (rst)
    word_strobe && port_word[LAT_POS] |-> port_word[OE_POS] && !port_word[CLK_POS])
    else $error("latch word without blanking");

endmodule

/* rtl/led_panel_scan_generator.sv */
// Scan generator for a split-half RGB LED panel. Commands enter on start while busy is low,
// one per clock: kind 0 writes a pixel into the back buffer, kind 1 produces the next
// panel port word, kind 2 swaps buffers. Each advance yields one beat on word_strobe,
// registered first in s1_valid and then in word_strobe; the strobe lasts one cycle and
// cannot be held off, so the receiver must take every beat. The pixel store is held as
// eight 4096 x 3 bit banks (plane by panel half). After reset the store is zeroed by a
// clear pass over all 4096 addresses during which busy is high; register writes over the
// APB port are taken at any time.
module led_panel_scan_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [5:0]  col,
  input  logic [5:0]  row,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        word_strobe,
  output logic [15:0] port_word,
  output logic [3:0]  hold_ticks,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lps_pkg::*;

  cfg_t                  cfg;
  mem_cmd_t              mem_cmd;
  logic                  s1_valid;
  word_info_t            s1_info;
  rgb_t [MAX_PLANES-1:0] rd_upper;
  rgb_t [MAX_PLANES-1:0] rd_lower;

  lps_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lps_scan_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .col      (col),
    .row      (row),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .cfg      (cfg),
    .busy     (busy),
    .mem_cmd  (mem_cmd),
    .s1_valid (s1_valid),
    .s1_info  (s1_info)
  );

  for (genvar p = 0; p < MAX_PLANES; p++) begin : g_plane
    lps_plane_ram u_upper (
      .clk   (clk),
      .we    (mem_cmd.we_upper[p]),
      .waddr (mem_cmd.waddr),
      .wdata (mem_cmd.wdata[p]),
      .raddr (mem_cmd.raddr),
      .rdata (rd_upper[p])
    );
    lps_plane_ram u_lower (
      .clk   (clk),
      .we    (mem_cmd.we_lower[p]),
      .waddr (mem_cmd.waddr),
      .wdata (mem_cmd.wdata[p]),
      .raddr (mem_cmd.raddr),
      .rdata (rd_lower[p])
    );
  end

  lps_word_out u_out (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1_info     (s1_info),
    .rd_upper    (rd_upper),
    .rd_lower    (rd_lower),
    .word_strobe (word_strobe),
    .port_word   (port_word),
    .hold_ticks  (hold_ticks),
    .frame_end   (frame_end)
  );

  a_advance_gives_beat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_ADVANCE |=> ##1 word_strobe)
    else $error("advance produced no beat");

  a_beat_from_advance: assert property (@(posedge clk) disable iff (rst)
    word_strobe |-> $past(start && !busy && kind == KIND_ADVANCE, 2))
    else $error("beat without advance");

endmodule

/* verif/lps_scan_checker.sv */
module lps_scan_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  kind,
  input  logic [5:0]  col,
  input  logic [5:0]  row,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        word_strobe,
  input  logic [15:0] port_word,
  input  logic [3:0]  hold_ticks,
  input  logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          words_pending,
  output int          words_checked
);
  import lps_pkg::*;

  typedef struct packed {
    logic [15:0] word;
    logic [3:0]  hold;
    logic        last;
  } panel_beat_t;

  panel_beat_t due_beats[$];
  panel_beat_t fresh_beat;

  // {buffer, plane, row, column}; bits 0-2 upper half RGB, bits 3-5 lower half RGB
  logic [5:0] plane_mem [16384];

  logic [6:0] cols_q;
  logic [5:0] rows_q;
  logic [2:0] planes_q;
  logic       show_a;      // 1: buffer 0 is on the panel, writes land in buffer 1
  logic [1:0] scan_pl;
  logic [4:0] scan_rw;
  logic [7:0] scan_sl;

  function automatic int unsigned sat_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [15:0] lane_bits(input logic [5:0] e);
    logic [15:0] w;
    w = '0;
    w[0] = e[0];
    w[1] = e[1];
    w[UPPER_BLUE_POS] = e[2];
    w[3] = e[3];
    w[4] = e[4];
    w[5] = e[5];
    return w;
  endfunction

  function automatic logic [15:0] sel_field(input int unsigned r);
    return 16'((r & 31) << SEL_POS);
  endfunction

  task automatic store_pixel(input logic [5:0] c, input logic [5:0] y,
                             input logic [7:0] r8, input logic [7:0] g8,
                             input logic [7:0] b8);
    int unsigned ncol, nrow, npl, rr;
    logic        lower;
    logic [3:0]  rp, gp, bp;
    logic [13:0] a;
    logic [5:0]  e;
    ncol = sat_reg(cols_q, MAX_COLUMNS);
    nrow = sat_reg(rows_q, MAX_SCAN_ROWS);
    npl  = sat_reg(planes_q, MAX_PLANES);
    if (c >= ncol || y >= 2 * nrow) return;
    lower = (y >= nrow);
    rr = lower ? y - nrow : y;
    rp = r8[7:4];
    gp = g8[7:4];
    bp = b8[7:4];
    for (int p = 0; p < npl; p++) begin
      a = {show_a, 2'(p), 5'(rr), c};
      e = plane_mem[a];
      if (lower) e[5:3] = {bp[p], gp[p], rp[p]};
      else e[2:0] = {bp[p], gp[p], rp[p]};
      plane_mem[a] = e;
    end
  endtask

  task automatic swap_buffers();
    int unsigned npl;
    npl = sat_reg(planes_q, MAX_PLANES);
    show_a = ~show_a;
    scan_pl = (scan_pl + 1 >= npl) ? 2'd0 : scan_pl + 2'd1;
    scan_rw = '0;
    scan_sl = '0;
  endtask

  task automatic next_beat(output panel_beat_t nb);
    int unsigned ncol, nrow, npl, slots, prevr, s;
    logic [13:0] a;
    logic [15:0] w;
    ncol  = sat_reg(cols_q, MAX_COLUMNS);
    nrow  = sat_reg(rows_q, MAX_SCAN_ROWS);
    npl   = sat_reg(planes_q, MAX_PLANES);
    slots = 2 * ncol + 4;
    // config may have shrunk under the running scan
    if (scan_pl >= npl) begin
      scan_pl = '0;
      scan_rw = '0;
      scan_sl = '0;
    end
    if (scan_rw >= nrow) begin
      scan_rw = '0;
      scan_sl = '0;
    end
    if (scan_sl >= slots) scan_sl = '0;

    prevr = (scan_rw == 0) ? nrow - 1 : scan_rw - 1;
    s = scan_sl;
    if (s < 2 * ncol) begin
      a = {~show_a, scan_pl, scan_rw, 6'(s >> 1)};
      w = lane_bits(plane_mem[a]) | sel_field(prevr);
      if (s % 2 == 1) w[CLK_POS] = 1'b1;
    end else if (s == 2 * ncol) begin
      w = sel_field(prevr);
      w[OE_POS] = 1'b1;
    end else if (s == 2 * ncol + 1) begin
      w = sel_field(scan_rw);
      w[OE_POS] = 1'b1;
      w[LAT_POS] = 1'b1;
    end else begin
      w = sel_field(scan_rw);
    end
    nb.word = w;
    nb.hold = 4'(1 << scan_pl);
    nb.last = (scan_pl == npl - 1) && (scan_rw == nrow - 1) && (s == slots - 1);

    if (s + 1 >= slots) begin
      scan_sl = '0;
      if (scan_rw + 1 >= nrow) begin
        scan_rw = '0;
        scan_pl = (scan_pl + 1 >= npl) ? 2'd0 : scan_pl + 2'd1;
      end else begin
        scan_rw = scan_rw + 5'd1;
      end
    end else begin
      scan_sl = scan_sl + 8'd1;
    end
  endtask

  task automatic check_beat();
    panel_beat_t want;
    if (due_beats.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected beat, expected none, got port_word %h hold %0d frame_end %b",
               $time, port_word, hold_ticks, frame_end);
    end else begin
      want = due_beats.pop_front();
      words_checked++;
      if (port_word !== want.word) begin
        fail_count++;
        $display("%0t: port_word expected %h got %h", $time, want.word, port_word);
      end
      if (hold_ticks !== want.hold) begin
        fail_count++;
        $display("%0t: hold_ticks expected %0d got %0d", $time, want.hold, hold_ticks);
      end
      if (frame_end !== want.last) begin
        fail_count++;
        $display("%0t: frame_end expected %b got %b", $time, want.last, frame_end);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16384; i++) plane_mem[i] = '0;
      due_beats.delete();
      fail_count    = 0;
      words_checked = 0;
      cols_q   = COLUMNS_RESET;
      rows_q   = ROWS_RESET;
      planes_q = PLANES_RESET;
      show_a   = 1'b1;
      scan_pl  = '0;
      scan_rw  = '0;
      scan_sl  = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_COLUMNS: cols_q = pwdata[6:0];
          REG_ROWS:    rows_q = pwdata[5:0];
          REG_PLANES:  planes_q = pwdata[2:0];
          default: ;
        endcase
      end
      if (word_strobe) check_beat();
      if (start && !busy) begin
        case (kind)
          KIND_WRITE:   store_pixel(col, row, red, green, blue);
          KIND_ADVANCE: begin
            next_beat(fresh_beat);
            due_beats.push_back(fresh_beat);
          end
          KIND_SWAP:    swap_buffers();
          default: ;
        endcase
      end
    end
    words_pending = due_beats.size();
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  import lps_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 68;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [5:0]  col;
  logic [5:0]  row;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        word_strobe;
  logic [15:0] port_word;
  logic [3:0]  hold_ticks;
  logic        frame_end;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int words_pending;
  int words_checked;

  logic took_cmd;
  bit   idle_on;
  int   items_sent;
  int   cycle_count;

  // raw register values per phase; zeros and oversize values exercise the clamping
  int unsigned cfg_cols   [PHASES] = '{2, 1, 0, 3, 64, 127, 4, 2, 5, 1};
  int unsigned cfg_rows   [PHASES] = '{2, 1, 0, 3, 32, 63, 2, 3, 1, 4};
  int unsigned cfg_planes [PHASES] = '{4, 1, 0, 2, 4, 7, 3, 4, 2, 4};

  led_panel_scan_generator u_dut (.*);

  lps_scan_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    took_cmd <= start && !busy;
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[led_panel_scan_generator] ERROR");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input int unsigned v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = ($urandom & ~32'h7f) | v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // hold start until the command is taken, then maybe leave a gap
  task automatic send_cmd(input logic [1:0] k, input logic [5:0] c, input logic [5:0] y,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    start = 1'b1;
    kind  = k;
    col   = c;
    row   = y;
    red   = r;
    green = g;
    blue  = b;
    do @(negedge clk); while (!took_cmd);
    if (k != KIND_UNUSED) items_sent++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic send_random(input int unsigned ncol, input int unsigned nrow);
    int unsigned pick;
    logic [1:0]  k;
    logic [5:0]  c, y;
    pick = $urandom_range(0, 99);
    if (pick < 22) k = KIND_WRITE;
    else if (pick < 92) k = KIND_ADVANCE;
    else if (pick < 97) k = KIND_SWAP;
    else k = KIND_UNUSED;
    c = 6'($urandom);
    y = 6'($urandom);
    // most writes land on the panel, a few may fall outside
    if (k == KIND_WRITE && $urandom_range(0, 9) != 0) begin
      c = 6'($urandom_range(0, ncol - 1));
      y = 6'($urandom_range(0, 2 * nrow - 1));
    end
    send_cmd(k, c, y, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    start = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned ncol, nrow;
    int          first;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_WRITE;
    col = '0;
    row = '0;
    red = '0;
    green = '0;
    blue = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part on the reset geometry: 64 columns, 16 rows per half, one plane
    send_cmd(KIND_WRITE, 6'd0, 6'd0, 8'hff, 8'hff, 8'hff);
    send_cmd(KIND_WRITE, 6'd63, 6'd31, 8'hf0, 8'h80, 8'h10);
    send_cmd(KIND_WRITE, 6'd1, 6'd16, 8'h0f, 8'h1f, 8'hff);
    send_cmd(KIND_WRITE, 6'd63, 6'd32, 8'hff, 8'hff, 8'hff);   // row off the panel
    send_cmd(KIND_WRITE, 6'd0, 6'd63, 8'hff, 8'h00, 8'hff);    // row off the panel
    send_cmd(KIND_UNUSED, 6'd63, 6'd63, 8'hff, 8'hff, 8'hff);
    send_cmd(KIND_ADVANCE, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(KIND_SWAP, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
    repeat (6) send_cmd(KIND_ADVANCE, 6'd63, 6'd63, 8'hff, 8'hff, 8'hff);
    send_cmd(KIND_WRITE, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(KIND_SWAP, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
    repeat (4) send_cmd(KIND_ADVANCE, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);

    // random phases, registers rewritten only once the block has gone quiet
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      apb_write(REG_COLUMNS, cfg_cols[ph]);
      apb_write(REG_ROWS, cfg_rows[ph]);
      apb_write(REG_PLANES, cfg_planes[ph]);
      ncol = (cfg_cols[ph] == 0) ? 1 : (cfg_cols[ph] > MAX_COLUMNS) ? MAX_COLUMNS : cfg_cols[ph];
      nrow = (cfg_rows[ph] == 0) ? 1 :
             (cfg_rows[ph] > MAX_SCAN_ROWS) ? MAX_SCAN_ROWS : cfg_rows[ph];
      idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) send_random(ncol, nrow);
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Sent %0d commands across %0d register settings; %0d port words compared.",
             items_sent, PHASES + 1, words_checked);
    if (fail_count == 0 && words_pending == 0) begin
      $display("[led_panel_scan_generator] OK");
    end else begin
      $display("[led_panel_scan_generator] ERROR");
    end
    $finish;
  end

endmodule
